// ===== hdl/ipv4_prefix_acl_first_match_core_assert.svh =====
// Assertion macros used by the checker module of the prefix ACL core.
`ifndef IPV4_PREFIX_ACL_FIRST_MATCH_CORE_ASSERT_SVH
`define IPV4_PREFIX_ACL_FIRST_MATCH_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define IPACL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ipacl: implication check failed");

// Next-cycle implication, disabled while reset is low.
`define IPACL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ipacl: next-cycle check failed");

`endif

// ===== hdl/ipacl_pkg.sv =====
// Types, constants and helper functions of the IPv4 prefix ACL core.
package ipacl_pkg;

  localparam int unsigned MAX_RULES_DEF = 64;
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned PLEN_W        = 6;
  localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(ADDR_W);

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // One stored rule.
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [PLEN_W-1:0] plen;
    logic              allow;
  } rule_t;

  // Controller to datapath.
  typedef struct packed {
    logic append;     // write the incoming rule, latch the append result
    logic scan_start; // latch the lookup address, rewind the scan
    logic scan;       // read and compare one rule this cycle
    logic res_hit;    // latch the verdict of the matching rule
    logic res_miss;   // latch the default verdict
    logic load_out;   // move the pending result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic hit;
    logic done;
    logic out_free;
  } sts_t;

  function automatic logic [PLEN_W-1:0] sat_plen(input logic [PLEN_W-1:0] p);
    sat_plen = (p > PLEN_MAX) ? PLEN_MAX : p;
  endfunction

  // Leading-ones mask: bit 31 is set for any prefix of one or more.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] p);
    logic [ADDR_W-1:0] m;
    m = '0;
    for (int i = 0; i < ADDR_W; i++) begin
      m[ADDR_W-1-i] = (PLEN_W'(i) < p);
    end
    prefix_mask = m;
  endfunction

endpackage

// ===== hdl/ipacl_ctrl.sv =====
// Sequencer of the IPv4 prefix ACL core: accept, scan and emit.
module ipacl_ctrl
  import ipacl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_kind_i,
  input  sts_t sts_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i == KIND_APPEND) begin
            cmd_o.append = 1'b1;
            state_d      = ST_EMIT;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit) begin
          cmd_o.res_hit = 1'b1;
          state_d       = ST_EMIT;
        end else if (sts_i.done) begin
          cmd_o.res_miss = 1'b1;
          state_d        = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== hdl/ipacl_dp.sv =====
// Datapath of the IPv4 prefix ACL core: rule memory, scan compare, result registers.
module ipacl_dp
  import ipacl_pkg::*;
#(
  parameter int unsigned MAX_RULES = MAX_RULES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [ADDR_W-1:0] in_address_i,
  input  logic [PLEN_W-1:0] in_prefix_len_i,
  input  logic              in_rule_allow_i,
  input  logic              cfg_we_i,
  input  logic              cfg_data_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic              out_allowed_o,
  output logic              out_matched_o,
  output logic              out_dropped_o
);

  localparam int unsigned CNT_W = $clog2(MAX_RULES + 1);
  localparam int unsigned IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_RULES);

  rule_t             mem [MAX_RULES];
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  rd_idx_q;
  logic              rd_vld_q;
  rule_t             rd_q;
  logic [ADDR_W-1:0] addr_q;
  logic              dflt_q;
  logic              res_allowed_q, res_matched_q, res_dropped_q;
  logic              out_vld_q;
  logic              out_allowed_q, out_matched_q, out_dropped_q;
  logic              full;
  logic              issue;
  rule_t             wr_rule;

  assign full  = (cnt_q == CNT_FULL);
  assign issue = cmd_i.scan && (rd_idx_q < cnt_q);

  assign wr_rule.base  = in_address_i;
  assign wr_rule.plen  = sat_plen(in_prefix_len_i);
  assign wr_rule.allow = in_rule_allow_i;

  // Rule memory: one write port at the fill count, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) begin
      mem[cnt_q[IDX_W-1:0]] <= wr_rule;
    end
    if (issue) begin
      rd_q <= mem[rd_idx_q[IDX_W-1:0]];
    end
    if (cmd_i.scan_start) begin
      addr_q <= in_address_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_idx_q <= '0;
      rd_vld_q <= 1'b0;
      dflt_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dflt_q <= cfg_data_i;
      end
      if (cmd_i.append && !full) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.scan_start) begin
        rd_idx_q <= '0;
        rd_vld_q <= 1'b0;
      end else if (cmd_i.scan) begin
        rd_vld_q <= issue;
        if (issue) begin
          rd_idx_q <= rd_idx_q + CNT_W'(1);
        end
      end
    end
  end

  assign sts_o.hit      = rd_vld_q && (((addr_q ^ rd_q.base) & prefix_mask(rd_q.plen)) == '0);
  assign sts_o.done     = !rd_vld_q && (rd_idx_q >= cnt_q);
  assign sts_o.out_free = !out_vld_q || !out_stall_i;

  // Pending result, held until the output register is free.
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      res_allowed_q <= 1'b0;
      res_matched_q <= 1'b0;
      res_dropped_q <= full;
    end else if (cmd_i.res_hit) begin
      res_allowed_q <= rd_q.allow;
      res_matched_q <= 1'b1;
      res_dropped_q <= 1'b0;
    end else if (cmd_i.res_miss) begin
      res_allowed_q <= dflt_q;
      res_matched_q <= 1'b0;
      res_dropped_q <= 1'b0;
    end
    if (cmd_i.load_out) begin
      out_allowed_q <= res_allowed_q;
      out_matched_q <= res_matched_q;
      out_dropped_q <= res_dropped_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_allowed_o = out_allowed_q;
  assign out_matched_o = out_matched_q;
  assign out_dropped_o = out_dropped_q;

endmodule

// ===== hdl/ipv4_prefix_acl_first_match_core.sv =====
// Top level of the IPv4 prefix access control list core, first-match lookup.
//
// Keeps an ordered list of up to MAX_RULES rules (base address, prefix length
// 0..32, allow/deny) and answers every input item with exactly one result item.
// An append item (kind 0) writes its rule behind the last one; prefix lengths
// above 32 are saturated to 32, and a full list refuses the rule and reports
// dropped. A lookup item (kind 1) walks the rules in load order, one rule per
// cycle through the single read port of the rule memory, and stops at the first
// rule whose prefix covers the address; with no covering rule the verdict comes
// from default_allow, which the user must write over the cfg port only while the
// core is idle; the core itself does not enforce this. An append goes from idle
// to the emit state; a lookup goes from idle through the scan state, which reads
// and compares the rules, to the emit state. The result moves into the output
// register as the core returns to idle, so it is there when the next item can
// be taken; a previous result still stalled in that register holds the core
// until it leaves. The next item is taken as soon as the result has moved into
// the output register, even while that register is still stalled downstream.
// The rule store needs no clearing after reset.
module ipv4_prefix_acl_first_match_core
  import ipacl_pkg::*;
#(
  parameter int unsigned MAX_RULES = MAX_RULES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // item input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              in_kind_i,
  input  logic [ADDR_W-1:0] in_address_i,
  input  logic [PLEN_W-1:0] in_prefix_len_i,
  input  logic              in_rule_allow_i,
  // result output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              out_allowed_o,
  output logic              out_matched_o,
  output logic              out_dropped_o,
  // default_allow register write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic busy;

  // Always taken, unchecked; the user must send config only while core is idle.
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;

  ipacl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_kind_i),
    .sts_i      (sts),
    .busy_o     (busy),
    .cmd_o      (cmd)
  );

  ipacl_dp #(
    .MAX_RULES (MAX_RULES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_address_i    (in_address_i),
    .in_prefix_len_i (in_prefix_len_i),
    .in_rule_allow_i (in_rule_allow_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_allowed_o   (out_allowed_o),
    .out_matched_o   (out_matched_o),
    .out_dropped_o   (out_dropped_o)
  );

endmodule

// ===== hdl/ipacl_chk.sv =====
// Port-level checker of the IPv4 prefix ACL core and its bind.
`include "ipv4_prefix_acl_first_match_core_assert.svh"

module ipacl_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic out_allowed_o,
  input logic out_matched_o,
  input logic out_dropped_o
);

  // Hold a stalled result.
  `IPACL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `IPACL_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable({out_allowed_o, out_matched_o, out_dropped_o}))
  // A dropped append carries no verdict.
  `IPACL_ASSERT_IMP(a_drop_clean, clk_i, rst_ni, out_valid_o && out_dropped_o, !out_allowed_o && !out_matched_o)
  // One item at a time: busy right after an accept.
  `IPACL_ASSERT_NXT(a_busy_after_acc, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind ipv4_prefix_acl_first_match_core ipacl_chk u_ipacl_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_allowed_o (out_allowed_o),
  .out_matched_o (out_matched_o),
  .out_dropped_o (out_dropped_o)
);

// ===== tb/ipv4_prefix_acl_first_match_core_tb.sv =====
// Self-checking testbench of the IPv4 prefix ACL first-match core.
`timescale 1ns / 1ps

module ipv4_prefix_acl_first_match_core_tb;
  import ipacl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 120;

  // One result item as the core reports it.
  typedef struct packed {
    logic allowed;
    logic matched;
    logic dropped;
  } verdict_t;

  // Rule list mirror plus the queue of verdicts still owed by the core.
  class acl_verdict_scoreboard;
    logic [ADDR_W-1:0] rule_base  [MAX_RULES_DEF];
    logic [PLEN_W-1:0] rule_plen  [MAX_RULES_DEF];
    logic              rule_allow [MAX_RULES_DEF];
    int unsigned       rule_count;
    logic              default_allow;
    verdict_t          expected_verdicts [$];
    int unsigned       mismatch_count;

    function new();
      for (int i = 0; i < MAX_RULES_DEF; i++) begin
        rule_base[i]  = '0;
        rule_plen[i]  = '0;
        rule_allow[i] = 1'b0;
      end
      rule_count     = 0;
      default_allow  = 1'b0;
      mismatch_count = 0;
    endfunction

    // Leading-ones mask; a zero prefix shifts nothing, so the mask is zero and covers everything.
    static function logic [ADDR_W-1:0] cover_mask(input logic [PLEN_W-1:0] plen);
      logic [ADDR_W-1:0] ones;
      ones = '1;
      return ~(ones >> plen);
    endfunction

    function int unsigned pending();
      return expected_verdicts.size();
    endfunction

    // Work out the verdict of an accepted item and update the rule list.
    function void record_item(input logic kind, input logic [ADDR_W-1:0] addr,
                              input logic [PLEN_W-1:0] plen, input logic act);
      verdict_t v;
      v = '0;
      if (kind == KIND_APPEND) begin
        if (rule_count >= MAX_RULES_DEF) begin
          v.dropped = 1'b1;
        end else begin
          rule_base[rule_count]  = addr;
          rule_plen[rule_count]  = (plen > PLEN_MAX) ? PLEN_MAX : plen;
          rule_allow[rule_count] = act;
          rule_count++;
        end
      end else begin
        v.allowed = default_allow;
        for (int i = 0; i < rule_count; i++) begin
          if (((addr ^ rule_base[i]) & cover_mask(rule_plen[i])) == '0) begin
            v.matched = 1'b1;
            v.allowed = rule_allow[i];
            break;
          end
        end
      end
      expected_verdicts = {expected_verdicts, v};
    endfunction

    function void check_verdict(input verdict_t got);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: allowed=%0b matched=%0b dropped=%0b",
                   got.allowed, got.matched, got.dropped);
        return;
      end
      want = expected_verdicts.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display({"verdict mismatch: expected allowed=%0b matched=%0b dropped=%0b,",
                    " got allowed=%0b matched=%0b dropped=%0b"},
                   want.allowed, want.matched, want.dropped,
                   got.allowed, got.matched, got.dropped);
      end
    endfunction
  endclass

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_stall_o;
  logic              in_kind_i       = KIND_APPEND;
  logic [ADDR_W-1:0] in_address_i    = '0;
  logic [PLEN_W-1:0] in_prefix_len_i = '0;
  logic              in_rule_allow_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i     = 1'b0;
  logic              out_allowed_o;
  logic              out_matched_o;
  logic              out_dropped_o;
  logic              cfg_valid_i     = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_data_i      = 1'b0;

  // Handshake between the stimulus and the receiver model.
  bit hold_request = 1'b0;
  bit rx_quiet     = 1'b0;

  int unsigned cycle_count = 0;
  acl_verdict_scoreboard sb = new();

  ipv4_prefix_acl_first_match_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_kind_i       (in_kind_i),
    .in_address_i    (in_address_i),
    .in_prefix_len_i (in_prefix_len_i),
    .in_rule_allow_i (in_rule_allow_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_allowed_o   (out_allowed_o),
    .out_matched_o   (out_matched_o),
    .out_dropped_o   (out_dropped_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Sample both channels at the rising edge, before the core updates anything.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.record_item(in_kind_i, in_address_i, in_prefix_len_i, in_rule_allow_i);
      if (out_valid_o && !out_stall_i)
        sb.check_verdict({out_allowed_o, out_matched_o, out_dropped_o});
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver model: random stalls, quiet stretches, and one long hold-off on
  // request so that the core backs up and stalls its input.
  initial begin
    int unsigned run_len;
    int unsigned stall_len;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
        hold_request = 1'b0;
      end else begin
        run_len = $urandom_range(1, 16);
        repeat (run_len) begin
          @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
        stall_len = rx_quiet ? 0 : pick_gap();
        repeat (stall_len) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  // Offer one item and hold it until the core takes it.
  task automatic drive_item(input logic kind, input logic [ADDR_W-1:0] addr,
                            input logic [PLEN_W-1:0] plen, input logic act);
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    in_kind_i       <= kind;
    in_address_i    <= addr;
    in_prefix_len_i <= plen;
    in_rule_allow_i <= act;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic sender_idle(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Drop valid and wait until every owed verdict has come back.
  task automatic drain_verdicts();
    sender_idle(1);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Write default_allow; only called with the core idle.
  task automatic write_default_allow(input logic value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.default_allow = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned       sent_rules;
    int unsigned       idx;
    int unsigned       r;
    logic              kind;
    logic              act;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] m;
    logic [PLEN_W-1:0] plen;

    sent_rules = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_default_allow(1'b0);

    // Directed: lookups on the empty list, ignored lookup fields all ones.
    drive_item(KIND_LOOKUP, 32'h0000_0000, 6'd0, 1'b0);
    drive_item(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd63, 1'b1);
    // Build a list with a shadowed rule, saturated prefixes and host routes.
    drive_item(KIND_APPEND, 32'h0A00_0000, 6'd8, 1'b1);
    drive_item(KIND_APPEND, 32'h0A01_0000, 6'd16, 1'b0);
    drive_item(KIND_APPEND, 32'hC0A8_0101, 6'd33, 1'b0);
    drive_item(KIND_APPEND, 32'hFFFF_FFFF, 6'd63, 1'b1);
    drive_item(KIND_APPEND, 32'h0000_0000, 6'd32, 1'b0);
    drive_item(KIND_APPEND, 32'hAC10_0000, 6'd12, 1'b1);
    sent_rules = 6;
    // Earlier /8 wins over the later /16.
    drive_item(KIND_LOOKUP, 32'h0A01_0203, 6'd0, 1'b0);
    drive_item(KIND_LOOKUP, 32'hC0A8_0101, 6'd5, 1'b1);
    drive_item(KIND_LOOKUP, 32'hC0A8_0100, 6'd0, 1'b0);
    drive_item(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0, 1'b0);
    drive_item(KIND_LOOKUP, 32'hFFFF_FFFE, 6'd0, 1'b0);
    drive_item(KIND_LOOKUP, 32'h0000_0000, 6'd0, 1'b0);
    drive_item(KIND_LOOKUP, 32'hAC1F_FFFF, 6'd0, 1'b0);
    drive_item(KIND_LOOKUP, 32'hAC20_0000, 6'd0, 1'b0);
    // Misses now take the allow default.
    drain_verdicts();
    write_default_allow(1'b1);
    drive_item(KIND_LOOKUP, 32'hC0A8_0100, 6'd0, 1'b0);
    drive_item(KIND_LOOKUP, 32'h5555_5555, 6'd0, 1'b0);
    drive_item(KIND_LOOKUP, 32'h0AFF_FFFF, 6'd0, 1'b0);

    // Random phases: grow the list slowly, aim nearly half of the lookups near stored rules.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_verdicts();
      write_default_allow(phase >= 6 ? logic'($urandom_range(0, 1)) : logic'(phase % 2));
      rx_quiet = (phase == 3 || phase == 5);
      // Long receiver hold-off while the sender keeps offering.
      if (phase == 1) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Pause mid-phase until the core has answered everything.
        if (phase == 4 && n == PHASE_ITEMS / 2) drain_verdicts();
        if (phase != 5) sender_idle(pick_gap());
        r = $urandom_range(0, 99);
        if (sent_rules < MAX_RULES_DEF) kind = (r < 15) ? KIND_APPEND : KIND_LOOKUP;
        else kind = (r < 8) ? KIND_APPEND : KIND_LOOKUP;
        act = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (kind == KIND_APPEND) begin
          // The last free slot gets a match-all rule; full-list appends take any prefix.
          if (sent_rules == MAX_RULES_DEF - 1) plen = '0;
          else if (sent_rules >= MAX_RULES_DEF) plen = PLEN_W'($urandom_range(0, 63));
          else if (r < 80) plen = PLEN_W'($urandom_range(1, 32));
          else plen = PLEN_W'($urandom_range(33, 63));
          if (sb.rule_count > 0 && $urandom_range(0, 9) < 3) begin
            // Nest inside or overlap an existing rule to test load order.
            idx  = $urandom_range(0, sb.rule_count - 1);
            addr = sb.rule_base[idx] ^ ($urandom & ~sb.cover_mask(sb.rule_plen[idx]));
          end else begin
            addr = $urandom;
          end
          sent_rules++;
        end else begin
          plen = PLEN_W'($urandom_range(0, 63));
          if (sb.rule_count > 0 && r < 45) begin
            idx  = $urandom_range(0, sb.rule_count - 1);
            m    = sb.cover_mask(sb.rule_plen[idx]);
            addr = (sb.rule_base[idx] & m) | ($urandom & ~m);
            // Near miss: flip one bit inside the prefix.
            if (r < 15 && sb.rule_plen[idx] != 0)
              addr[ADDR_W - 1 - $urandom_range(0, sb.rule_plen[idx] - 1)] ^= 1'b1;
          end else begin
            addr = $urandom;
          end
        end
        drive_item(kind, addr, plen, act);
      end
    end

    drain_verdicts();
    // Keep waiting after the drain to catch stray results.
    repeat (MAX_RULES_DEF + 8) @(negedge clk_i);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
